@@ src/mbgd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mouse button gesture detector package
// Shared widths, event codes, register indexes and the per-sample record.
// ----------------------------------------------------------------------------
package mbgd_pkg;

    localparam int NUM_BUTTONS = 3;
    localparam int COORD_WIDTH = 12;
    localparam int TIMER_WIDTH = 16;

    localparam int ELAPSED_W = 10;
    localparam int SPAN_W    = 16;
    localparam int THRESH_W  = 12;
    localparam int KIND_W    = 3;
    localparam int BTN_IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int DELTA_W   = COORD_WIDTH + 1;

    // Each button reports at most two events per sample.
    localparam int NUM_SLOTS = 2 * NUM_BUTTONS;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);

    localparam int TCMP_W = (TIMER_WIDTH > SPAN_W) ? TIMER_WIDTH : SPAN_W;
    localparam int TSUM_W = ((TIMER_WIDTH > ELAPSED_W) ? TIMER_WIDTH : ELAPSED_W) + 1;
    localparam int OCMP_W = (DELTA_W > THRESH_W) ? DELTA_W : THRESH_W;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = (SPAN_W > THRESH_W) ? SPAN_W : THRESH_W;

    localparam logic [CFG_INDEX_W-1:0] REG_SPAN   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_THRESH = CFG_INDEX_W'(1);

    localparam logic [SPAN_W-1:0]   SPAN_RESET   = SPAN_W'(250);
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(5);

    localparam int IN_FIELDS_W  = NUM_BUTTONS + 2 * COORD_WIDTH + ELAPSED_W;
    localparam int S_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = KIND_W + BTN_IDX_W + 4 * COORD_WIDTH + 2 * DELTA_W;
    localparam int M_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind EV_PRESS      = t_kind'(0);
    localparam t_kind EV_DOUBLE     = t_kind'(1);
    localparam t_kind EV_RELEASE    = t_kind'(2);
    localparam t_kind EV_DRAG_END   = t_kind'(3);
    localparam t_kind EV_CLICK      = t_kind'(4);
    localparam t_kind EV_DRAG_START = t_kind'(5);
    localparam t_kind EV_DRAG       = t_kind'(6);

    // Classified sample: slot 2b is the first event of button b, slot 2b+1 the second.
    typedef struct packed {
        logic [NUM_SLOTS-1:0]                    valid;
        t_kind [NUM_SLOTS-1:0]                   kind;
        logic [NUM_BUTTONS-1:0][COORD_WIDTH-1:0] start_x;
        logic [NUM_BUTTONS-1:0][COORD_WIDTH-1:0] start_y;
        logic [COORD_WIDTH-1:0]                  x;
        logic [COORD_WIDTH-1:0]                  y;
        logic signed [DELTA_W-1:0]               dx;
        logic signed [DELTA_W-1:0]               dy;
    } t_sample_rec;

endpackage

@@ src/mbgd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gesture detector front end
// Accepts poll samples, tracks per-button state and classifies the events.
// ----------------------------------------------------------------------------
module mbgd_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // buttons_down, cursor_x, cursor_y, elapsed_ms (from bit 0 up), zero padded
    input  logic [mbgd_pkg::S_TDATA_W-1:0]       i_s_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mbgd_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [mbgd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_q_full,
    output logic                                 o_push,
    output mbgd_pkg::t_sample_rec                o_rec
);
    import mbgd_pkg::*;

    logic [SPAN_W-1:0]                       r_span;
    logic [THRESH_W-1:0]                     r_thresh;
    logic [NUM_BUTTONS-1:0]                  r_prev_buttons;
    logic [COORD_WIDTH-1:0]                  r_prev_x;
    logic [COORD_WIDTH-1:0]                  r_prev_y;
    logic [NUM_BUTTONS-1:0][TIMER_WIDTH-1:0] r_since;
    logic [NUM_BUTTONS-1:0]                  r_was_double;
    logic [NUM_BUTTONS-1:0]                  r_dragging;
    logic [NUM_BUTTONS-1:0][COORD_WIDTH-1:0] r_press_x;
    logic [NUM_BUTTONS-1:0][COORD_WIDTH-1:0] r_press_y;

    logic [NUM_BUTTONS-1:0][TIMER_WIDTH-1:0] n_since;
    logic [NUM_BUTTONS-1:0]                  n_was_double;
    logic [NUM_BUTTONS-1:0]                  n_dragging;
    logic [NUM_BUTTONS-1:0][COORD_WIDTH-1:0] n_press_x;
    logic [NUM_BUTTONS-1:0][COORD_WIDTH-1:0] n_press_y;

    logic [NUM_BUTTONS-1:0]    now;
    logic [COORD_WIDTH-1:0]    cur_x;
    logic [COORD_WIDTH-1:0]    cur_y;
    logic [ELAPSED_W-1:0]      elapsed;
    logic                      accept;
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;

    assign now     = i_s_tdata[NUM_BUTTONS-1:0];
    assign cur_x   = i_s_tdata[NUM_BUTTONS +: COORD_WIDTH];
    assign cur_y   = i_s_tdata[NUM_BUTTONS + COORD_WIDTH +: COORD_WIDTH];
    assign elapsed = i_s_tdata[NUM_BUTTONS + 2 * COORD_WIDTH +: ELAPSED_W];

    assign o_s_tready  = !i_q_full;
    assign accept      = i_s_tvalid && !i_q_full;
    assign o_push      = accept;
    assign o_cfg_ready = 1'b1;

    assign delta_x = $signed({1'b0, cur_x}) - $signed({1'b0, r_prev_x});
    assign delta_y = $signed({1'b0, cur_y}) - $signed({1'b0, r_prev_y});

    always_comb begin
        logic                      press;
        logic                      rel;
        logic                      held;
        logic                      dbl;
        logic                      start_drag;
        logic signed [DELTA_W-1:0] off_x;
        logic signed [DELTA_W-1:0] off_y;
        logic [DELTA_W-1:0]        abs_x;
        logic [DELTA_W-1:0]        abs_y;
        logic [TIMER_WIDTH-1:0]    base;
        logic [TSUM_W-1:0]         sum;

        o_rec.x       = cur_x;
        o_rec.y       = cur_y;
        o_rec.dx      = delta_x;
        o_rec.dy      = delta_y;
        o_rec.start_x = r_press_x;
        o_rec.start_y = r_press_y;
        o_rec.valid   = '0;
        o_rec.kind    = '0;

        for (int b = 0; b < NUM_BUTTONS; b++) begin
            press = now[b] && !r_prev_buttons[b];
            rel   = !now[b] && r_prev_buttons[b];
            held  = now[b] && r_prev_buttons[b];
            dbl   = TCMP_W'(r_since[b]) <= TCMP_W'(r_span);

            // The offset is taken as an absolute value on both axes.
            off_x = $signed({1'b0, cur_x}) - $signed({1'b0, r_press_x[b]});
            off_y = $signed({1'b0, cur_y}) - $signed({1'b0, r_press_y[b]});
            abs_x = off_x[DELTA_W-1] ? DELTA_W'(-off_x) : DELTA_W'(off_x);
            abs_y = off_y[DELTA_W-1] ? DELTA_W'(-off_y) : DELTA_W'(off_y);
            start_drag = held && !r_dragging[b] &&
                         ((OCMP_W'(abs_x) > OCMP_W'(r_thresh)) ||
                          (OCMP_W'(abs_y) > OCMP_W'(r_thresh)));

            o_rec.valid[2*b] = press || rel || start_drag;
            o_rec.kind[2*b]  = press ? EV_PRESS : (rel ? EV_RELEASE : EV_DRAG_START);

            o_rec.valid[2*b+1] = (press && dbl) ||
                                 (rel && (r_dragging[b] || !r_was_double[b])) ||
                                 (held && (r_dragging[b] || start_drag));
            o_rec.kind[2*b+1]  = press ? EV_DOUBLE :
                                 (rel ? (r_dragging[b] ? EV_DRAG_END : EV_CLICK) : EV_DRAG);

            n_was_double[b] = press ? dbl : r_was_double[b];
            n_dragging[b]   = press ? 1'b0 : (start_drag ? 1'b1 : r_dragging[b]);
            n_press_x[b]    = press ? cur_x : r_press_x[b];
            n_press_y[b]    = press ? cur_y : r_press_y[b];

            // Timer restarts on a press, then the elapsed time is added with saturation.
            base = press ? '0 : r_since[b];
            sum  = TSUM_W'(base) + TSUM_W'(elapsed);
            n_since[b] = (sum > TSUM_W'({TIMER_WIDTH{1'b1}})) ? {TIMER_WIDTH{1'b1}}
                                                               : sum[TIMER_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span   <= SPAN_RESET;
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SPAN:   r_span   <= i_cfg_data[SPAN_W-1:0];
                REG_THRESH: r_thresh <= i_cfg_data[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_buttons <= '0;
            r_prev_x       <= '0;
            r_prev_y       <= '0;
            r_since        <= '1;
            r_was_double   <= '0;
            r_dragging     <= '0;
            r_press_x      <= '0;
            r_press_y      <= '0;
        end else if (accept) begin
            r_prev_buttons <= now;
            r_prev_x       <= cur_x;
            r_prev_y       <= cur_y;
            r_since        <= n_since;
            r_was_double   <= n_was_double;
            r_dragging     <= n_dragging;
            r_press_x      <= n_press_x;
            r_press_y      <= n_press_y;
        end
    end

endmodule

@@ src/mbgd_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gesture detector sample queue
// Short queue of classified samples between the front end and the back end.
// ----------------------------------------------------------------------------
module mbgd_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  mbgd_pkg::t_sample_rec i_rec,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_valid,
    output mbgd_pkg::t_sample_rec o_rec
);
    import mbgd_pkg::*;

    t_sample_rec             r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   r_wr_ptr;
    logic [FIFO_PTR_W-1:0]   r_rd_ptr;
    logic [FIFO_PTR_W:0]     r_count;

    assign o_full  = (r_count == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("sample queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("sample queue read while empty");

endmodule

@@ src/mbgd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gesture detector back end
// Takes one classified sample at a time and sends its events one per cycle unless stalled.
// ----------------------------------------------------------------------------
module mbgd_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  mbgd_pkg::t_sample_rec          i_q_rec,
    output logic                           o_pop,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // event_kind, button_index, event_x, event_y, start_x, start_y,
    // delta_x, delta_y (from bit 0 up), zero padded
    output logic [mbgd_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic                           o_m_tlast
);
    import mbgd_pkg::*;

    t_sample_rec            r_rec;
    logic                   r_busy;
    logic [NUM_SLOTS-1:0]   r_pend;
    logic                   r_out_valid;
    logic [M_TDATA_W-1:0]   r_out_data;
    logic                   r_out_last;

    logic [SLOT_W-1:0]      sel;
    logic                   found;
    logic                   out_free;
    logic                   emit;
    logic [NUM_SLOTS-1:0]   pend_after;
    logic                   stay;
    t_kind                  kind;
    logic [BTN_IDX_W-1:0]   btn;
    logic                   is_drag;
    logic [COORD_WIDTH-1:0] sx;
    logic [COORD_WIDTH-1:0] sy;
    logic [DELTA_W-1:0]     dx;
    logic [DELTA_W-1:0]     dy;
    logic [M_TDATA_W-1:0]   word;

    // Lowest pending slot goes first, which keeps button and event order.
    always_comb begin
        sel = '0;
        for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
            if (r_pend[s]) begin
                sel = SLOT_W'(s);
            end
        end
    end

    assign found      = |r_pend;
    assign out_free   = !r_out_valid || i_m_tready;
    assign emit       = r_busy && found && out_free;
    assign pend_after = emit ? (r_pend & ~(NUM_SLOTS'(1) << sel)) : r_pend;
    assign stay       = r_busy && (pend_after != '0);
    assign o_pop      = i_q_valid && !stay;

    assign kind    = r_rec.kind[sel];
    assign btn     = BTN_IDX_W'(sel >> 1);
    assign is_drag = (kind == EV_DRAG_END) || (kind == EV_DRAG_START) || (kind == EV_DRAG);
    assign sx      = is_drag ? r_rec.start_x[btn] : '0;
    assign sy      = is_drag ? r_rec.start_y[btn] : '0;
    assign dx      = is_drag ? r_rec.dx : '0;
    assign dy      = is_drag ? r_rec.dy : '0;
    assign word    = M_TDATA_W'({dy, dx, sy, sx, r_rec.y, r_rec.x, btn, kind});

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_q_rec;
        end
        if (emit) begin
            r_out_data <= word;
            r_out_last <= (pend_after == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_pend <= i_q_rec.valid;
            end else begin
                r_busy <= stay;
                r_pend <= pend_after;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_pend == '0))
        else $error("events pending while back end is idle");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && found && r_out_valid && !i_m_tready) |=> $stable(r_pend))
        else $error("pending events changed while the output was stalled");

    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && ($countones(r_pend) == 1)) |=> (o_m_tvalid && o_m_tlast))
        else $error("final event of a sample not marked last");

endmodule

@@ src/mouse_button_gesture_detector_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mouse button gesture detector
// Turns poll samples into press, click, double click and drag events.
// ----------------------------------------------------------------------------
// Usage:
//   The sample channel (i_s_*) takes one poll sample per transfer. The event
//   channel (o_m_*) returns zero to six events per sample, one per transfer,
//   with o_m_tlast set on the final event of the sample; a sample that causes
//   no event produces no transfer. The configuration channel (i_cfg_*) writes
//   register 0 (double click span in ms) or register 1 (drag threshold in
//   pixels); o_cfg_ready is always high and other indexes are ignored.
//   The first event of a sample passes the sample queue, the back end's sample
//   register and its single output register. Throughput is one event per
//   cycle while the receiver is ready; the back end takes its next sample
//   while it sends the last event of the current one. The front end takes
//   a sample every cycle while the four-entry sample queue has room.
//   Reset clears button history, drag state and pending events, and restores
//   the register defaults (span 250, threshold 5). When the receiver stalls,
//   the held event stays put, the queue fills, and then o_s_tready drops.
// ----------------------------------------------------------------------------
module mouse_button_gesture_detector_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // buttons_down, cursor_x, cursor_y, elapsed_ms (from bit 0 up), zero padded
    input  logic [mbgd_pkg::S_TDATA_W-1:0]       i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // event_kind, button_index, event_x, event_y, start_x, start_y,
    // delta_x, delta_y (from bit 0 up), zero padded
    output logic [mbgd_pkg::M_TDATA_W-1:0]       o_m_tdata,
    output logic                                 o_m_tlast,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mbgd_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [mbgd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import mbgd_pkg::*;

    logic        q_full;
    logic        q_push;
    logic        q_pop;
    logic        q_valid;
    t_sample_rec push_rec;
    t_sample_rec pop_rec;

    mbgd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_rec       (push_rec)
    );

    mbgd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (push_rec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rec   (pop_rec)
    );

    mbgd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_rec    (pop_rec),
        .o_pop      (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

@@ test/mouse_button_gesture_detector_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mouse button gesture detector regression
// Sends poll samples into the detector and checks every returned event,
// field by field, against a cycle-free model of the gesture rules. A short
// table of hand-picked samples comes first, then random samples under
// several register settings, with random idling on both channels and one
// long receiver hold-off that backs the block up into its sample input.
// ----------------------------------------------------------------------------
module mouse_button_gesture_detector_unit_test;

    import mbgd_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 3000;
    localparam int MAX_SHOWN     = 10;
    localparam int RANDOM_ITEMS  = 28;
    localparam int SOAK_ITEMS    = 25;
    localparam int NUM_ROWS      = 23;
    localparam int COORD_MAX     = (1 << COORD_WIDTH) - 1;
    localparam int ELAPSED_MAX   = (1 << ELAPSED_W) - 1;

    // Register indexes outside the implemented set; writes to them are dropped.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = REG_THRESH + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] REG_NONE   = '1;

    // Row marker: the expected events come from the model, not from the table.
    localparam logic [1:0] FROM_MODEL = 2'd3;

    typedef struct packed {
        logic [S_TDATA_W-IN_FIELDS_W-1:0] pad;
        logic [ELAPSED_W-1:0]             elapsed;
        logic [COORD_WIDTH-1:0]           y;
        logic [COORD_WIDTH-1:0]           x;
        logic [NUM_BUTTONS-1:0]           buttons;
    } t_sample;

    typedef struct packed {
        logic [M_TDATA_W-OUT_FIELDS_W-1:0] pad;
        logic signed [DELTA_W-1:0]         dy;
        logic signed [DELTA_W-1:0]         dx;
        logic [COORD_WIDTH-1:0]            sy;
        logic [COORD_WIDTH-1:0]            sx;
        logic [COORD_WIDTH-1:0]            ey;
        logic [COORD_WIDTH-1:0]            ex;
        logic [BTN_IDX_W-1:0]              btn;
        t_kind                             kind;
    } t_gesture;

    typedef struct packed {
        t_gesture ev;
        logic     last;
    } t_expected;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] buttons;
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
        logic [ELAPSED_W-1:0]   el;
        logic [1:0]             n_typed;
        t_kind                  k0;
        logic [BTN_IDX_W-1:0]   b0;
        t_kind                  k1;
        logic [BTN_IDX_W-1:0]   b1;
    } t_row;

    // Hand-picked samples under the reset register values.
    t_row script [NUM_ROWS] = '{
        '{3'b000, 12'd4095, 12'd4095, 10'd1023, 2'd0, EV_PRESS, 2'd0, EV_PRESS, 2'd0},
        '{3'b001, 12'd4095, 12'd4095, 10'd10, 2'd1, EV_PRESS, 2'd0, EV_PRESS, 2'd0},
        '{3'b000, 12'd4095, 12'd4095, 10'd100, 2'd2, EV_RELEASE, 2'd0, EV_CLICK, 2'd0},
        '{3'b001, 12'd4095, 12'd4095, 10'd20, 2'd2, EV_PRESS, 2'd0, EV_DOUBLE, 2'd0},
        '{3'b000, 12'd4095, 12'd4095, 10'd230, 2'd1, EV_RELEASE, 2'd0, EV_PRESS, 2'd0},
        '{3'b001, 12'd4095, 12'd4095, 10'd251, 2'd2, EV_PRESS, 2'd0, EV_DOUBLE, 2'd0},
        '{3'b000, 12'd0, 12'd0, 10'd0, 2'd1, EV_RELEASE, 2'd0, EV_PRESS, 2'd0},
        '{3'b001, 12'd0, 12'd0, 10'd0, 2'd1, EV_PRESS, 2'd0, EV_PRESS, 2'd0},
        '{3'b001, 12'd5, 12'd5, 10'd0, 2'd0, EV_PRESS, 2'd0, EV_PRESS, 2'd0},
        '{3'b001, 12'd6, 12'd0, 10'd0, FROM_MODEL, EV_PRESS, 2'd0, EV_PRESS, 2'd0},
        '{3'b001, 12'd0, 12'd0, 10'd0, FROM_MODEL, EV_PRESS, 2'd0, EV_PRESS, 2'd0},
        '{3'b000, 12'd0, 12'd0, 10'd0, FROM_MODEL, EV_PRESS, 2'd0, EV_PRESS, 2'd0},
        '{3'b100, 12'd500, 12'd500, 10'd300, 2'd1, EV_PRESS, 2'd2, EV_PRESS, 2'd0},
        '{3'b100, 12'd500, 12'd494, 10'd0, FROM_MODEL, EV_PRESS, 2'd0, EV_PRESS, 2'd0},
        '{3'b110, 12'd500, 12'd494, 10'd0, FROM_MODEL, EV_PRESS, 2'd0, EV_PRESS, 2'd0},
        '{3'b000, 12'd500, 12'd494, 10'd0, FROM_MODEL, EV_PRESS, 2'd0, EV_PRESS, 2'd0},
        '{3'b111, 12'd0, 12'd0, 10'd0, FROM_MODEL, EV_PRESS, 2'd0, EV_PRESS, 2'd0},
        '{3'b111, 12'd4095, 12'd4095, 10'd0, FROM_MODEL, EV_PRESS, 2'd0, EV_PRESS, 2'd0},
        '{3'b111, 12'd0, 12'd0, 10'd0, FROM_MODEL, EV_PRESS, 2'd0, EV_PRESS, 2'd0},
        '{3'b111, 12'd4095, 12'd0, 10'd0, FROM_MODEL, EV_PRESS, 2'd0, EV_PRESS, 2'd0},
        '{3'b000, 12'd0, 12'd4095, 10'd1023, FROM_MODEL, EV_PRESS, 2'd0, EV_PRESS, 2'd0},
        '{3'b010, 12'd2730, 12'd1365, 10'd0, FROM_MODEL, EV_PRESS, 2'd0, EV_PRESS, 2'd0},
        '{3'b000, 12'd1365, 12'd2730, 10'd682, FROM_MODEL, EV_PRESS, 2'd0, EV_PRESS, 2'd0}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [S_TDATA_W-1:0]   i_s_tdata = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   o_m_tdata;
    logic                   o_m_tlast;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    logic hold_req = 1'b0;

    // Gesture model state and its copy of the registers.
    logic [SPAN_W-1:0]      span_ms;
    logic [THRESH_W-1:0]    thresh_px;
    logic [NUM_BUTTONS-1:0] prev_btns;
    logic [COORD_WIDTH-1:0] prev_x;
    logic [COORD_WIDTH-1:0] prev_y;
    logic [TIMER_WIDTH-1:0] press_timer [NUM_BUTTONS];
    logic                   double_flag [NUM_BUTTONS];
    logic                   dragging    [NUM_BUTTONS];
    logic [COORD_WIDTH-1:0] anchor_x    [NUM_BUTTONS];
    logic [COORD_WIDTH-1:0] anchor_y    [NUM_BUTTONS];

    t_expected batch [NUM_SLOTS];
    t_expected pending_events [$];

    int fail_count = 0;
    int send_calm = 0;
    int walk_x = 0;
    int walk_y = 0;
    logic [NUM_BUTTONS-1:0] walk_btns = '0;

    mouse_button_gesture_detector_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    task automatic note_failure(input string what, input t_expected want,
                                input t_expected got);
        fail_count++;
        if (fail_count <= MAX_SHOWN) begin
            $display("%s: expected kind %0d btn %0d xy %0d,%0d start %0d,%0d %s",
                     what, want.ev.kind, want.ev.btn, want.ev.ex, want.ev.ey, want.ev.sx,
                     want.ev.sy, $sformatf("delta %0d,%0d last %0b",
                                           want.ev.dx, want.ev.dy, want.last));
            $display("    got kind %0d btn %0d xy %0d,%0d start %0d,%0d delta %0d,%0d last %0b",
                     got.ev.kind, got.ev.btn, got.ev.ex, got.ev.ey, got.ev.sx,
                     got.ev.sy, got.ev.dx, got.ev.dy, got.last);
        end
    endtask

    function automatic void reset_gesture_model();
        span_ms   = SPAN_RESET;
        thresh_px = THRESH_RESET;
        prev_btns = '0;
        prev_x    = '0;
        prev_y    = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            press_timer[b] = '1;
            double_flag[b] = 1'b0;
            dragging[b]    = 1'b0;
            anchor_x[b]    = '0;
            anchor_y[b]    = '0;
        end
    endfunction

    function automatic t_expected make_event(input t_kind k, input int b, input t_sample s,
                                             input logic drag, input int dx, input int dy);
        t_expected e;
        e = '0;
        e.ev.kind = k;
        e.ev.btn  = BTN_IDX_W'(b);
        e.ev.ex   = s.x;
        e.ev.ey   = s.y;
        if (drag) begin
            e.ev.sx = anchor_x[b];
            e.ev.sy = anchor_y[b];
            e.ev.dx = DELTA_W'(dx);
            e.ev.dy = DELTA_W'(dy);
        end
        return e;
    endfunction

    // Classifies one sample into events (left in batch) and advances the model.
    function automatic int detect_gestures(input t_sample s);
        int n, dx, dy, ox, oy;
        logic cur, was;
        logic [TIMER_WIDTH:0] sum;
        n  = 0;
        dx = int'(s.x) - int'(prev_x);
        dy = int'(s.y) - int'(prev_y);
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            cur = s.buttons[b];
            was = prev_btns[b];
            if (cur && !was) begin
                batch[n] = make_event(EV_PRESS, b, s, 1'b0, 0, 0);
                n++;
                double_flag[b] = (press_timer[b] <= span_ms);
                press_timer[b] = '0;
                if (double_flag[b]) begin
                    batch[n] = make_event(EV_DOUBLE, b, s, 1'b0, 0, 0);
                    n++;
                end
                dragging[b] = 1'b0;
                anchor_x[b] = s.x;
                anchor_y[b] = s.y;
            end
            if (!cur && was) begin
                batch[n] = make_event(EV_RELEASE, b, s, 1'b0, 0, 0);
                n++;
                if (dragging[b]) begin
                    batch[n] = make_event(EV_DRAG_END, b, s, 1'b1, dx, dy);
                    n++;
                end else if (!double_flag[b]) begin
                    batch[n] = make_event(EV_CLICK, b, s, 1'b0, 0, 0);
                    n++;
                end
            end
            if (cur && was) begin
                ox = int'(s.x) - int'(anchor_x[b]);
                oy = int'(s.y) - int'(anchor_y[b]);
                if (ox < 0) ox = -ox;
                if (oy < 0) oy = -oy;
                if (!dragging[b] && (ox > int'(thresh_px) || oy > int'(thresh_px))) begin
                    dragging[b] = 1'b1;
                    batch[n] = make_event(EV_DRAG_START, b, s, 1'b1, dx, dy);
                    n++;
                end
                if (dragging[b]) begin
                    batch[n] = make_event(EV_DRAG, b, s, 1'b1, dx, dy);
                    n++;
                end
            end
        end
        // Timers advance only after this sample's presses have been judged.
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            sum = (TIMER_WIDTH + 1)'(press_timer[b]) + (TIMER_WIDTH + 1)'(s.elapsed);
            press_timer[b] = sum[TIMER_WIDTH] ? '1 : sum[TIMER_WIDTH-1:0];
        end
        prev_btns = s.buttons;
        prev_x    = s.x;
        prev_y    = s.y;
        if (n > 0) batch[n-1].last = 1'b1;
        return n;
    endfunction

    function automatic int sender_gap();
        int r;
        if (send_calm > 0) begin
            send_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 93) begin
            send_calm = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic int clamp_coord(input int v);
        if (v < 0) return 0;
        if (v > COORD_MAX) return COORD_MAX;
        return v;
    endfunction

    // Mostly small cursor steps around held buttons, with jumps now and then.
    function automatic t_sample next_random_sample();
        t_sample s;
        int r;
        s = '0;
        r = $urandom_range(0, 99);
        if (r < 30) walk_btns = walk_btns ^ NUM_BUTTONS'($urandom_range(1, 7));
        else if (r < 35) walk_btns = NUM_BUTTONS'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        if (r < 8) begin
            walk_x = $urandom_range(0, COORD_MAX);
            walk_y = $urandom_range(0, COORD_MAX);
        end else if (r < 12) begin
            walk_x = $urandom_range(0, 1) ? COORD_MAX : 0;
            walk_y = $urandom_range(0, 1) ? COORD_MAX : 0;
        end else begin
            walk_x = clamp_coord(walk_x + int'($urandom_range(0, 12)) - 6);
            walk_y = clamp_coord(walk_y + int'($urandom_range(0, 12)) - 6);
        end
        s.buttons = walk_btns;
        s.x       = COORD_WIDTH'(walk_x);
        s.y       = COORD_WIDTH'(walk_y);
        r = $urandom_range(0, 99);
        if (r < 25) s.elapsed = '0;
        else if (r < 80) s.elapsed = ELAPSED_W'($urandom_range(1, 150));
        else s.elapsed = ELAPSED_W'($urandom_range(0, ELAPSED_MAX));
        return s;
    endfunction

    // Offers one sample and returns at the edge where it is taken.
    task automatic send_sample(input t_sample s, input bit from_model);
        int gap, n;
        gap = sender_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= s;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        n = detect_gestures(s);
        if (from_model) begin
            for (int k = 0; k < n; k++) pending_events.push_back(batch[k]);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx == REG_SPAN) span_ms = val[SPAN_W-1:0];
        else if (idx == REG_THRESH) thresh_px = val[THRESH_W-1:0];
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // A sample with no events can still be in flight once the queue is empty.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) send_sample(next_random_sample(), 1'b1);
    endtask

    initial begin : stimulus
        t_sample   s;
        t_expected e;
        reset_gesture_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            s = '0;
            s.buttons = script[i].buttons;
            s.x       = script[i].x;
            s.y       = script[i].y;
            s.elapsed = script[i].el;
            send_sample(s, script[i].n_typed == FROM_MODEL);
            if (script[i].n_typed != FROM_MODEL) begin
                for (int k = 0; k < int'(script[i].n_typed); k++) begin
                    e = '0;
                    e.ev.kind = (k == 0) ? script[i].k0 : script[i].k1;
                    e.ev.btn  = (k == 0) ? script[i].b0 : script[i].b1;
                    e.ev.ex   = script[i].x;
                    e.ev.ey   = script[i].y;
                    e.last    = (k == int'(script[i].n_typed) - 1);
                    pending_events.push_back(e);
                end
            end
        end
        wait_drained();

        // Widest span: every press in the samples that follow becomes a double click.
        write_reg(REG_SPAN, CFG_DATA_W'(16'hFFFF));
        write_reg(REG_THRESH, '0);
        for (int i = 0; i < SOAK_ITEMS; i++) begin
            s = '0;
            s.x       = COORD_WIDTH'($urandom_range(0, COORD_MAX));
            s.y       = COORD_WIDTH'($urandom_range(0, COORD_MAX));
            s.elapsed = ELAPSED_W'(ELAPSED_MAX);
            send_sample(s, 1'b1);
        end
        walk_btns = '0;
        run_random(RANDOM_ITEMS);
        wait_drained();

        write_reg(REG_SPAN, '0);
        write_reg(REG_THRESH, CFG_DATA_W'(COORD_MAX));
        run_random(RANDOM_ITEMS);
        wait_drained();

        write_reg(REG_SPAN, CFG_DATA_W'($urandom_range(100, 600)));
        write_reg(REG_THRESH, CFG_DATA_W'($urandom_range(1, 12)));
        hold_req <= 1'b1;
        run_random(RANDOM_ITEMS);
        wait_drained();

        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        write_reg(REG_NONE, CFG_DATA_W'($urandom));
        run_random(RANDOM_ITEMS);
        wait_drained();

        if (fail_count == 0) begin
            $display("mouse_button_gesture_detector_unit regression: pass");
        end else begin
            $display("mouse_button_gesture_detector_unit regression: fail");
        end
        $finish;
    end

    // Event receiver: random back-pressure plus one long hold-off on request.
    initial begin : event_sink
        int r, stall_left, calm_left;
        bit hold_done;
        stall_left = 0;
        calm_left  = 0;
        hold_done  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                i_m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    i_m_tready <= 1'b1;
                end else if (r < 85) begin
                    stall_left = $urandom_range(0, 2);
                    i_m_tready <= 1'b0;
                end else if (r < 95) begin
                    calm_left = $urandom_range(20, 60);
                    i_m_tready <= 1'b1;
                end else begin
                    stall_left = $urandom_range(8, 40);
                    i_m_tready <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_events
        t_expected want, got;
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            got.ev   = t_gesture'(o_m_tdata);
            got.last = o_m_tlast;
            if (pending_events.size() == 0) begin
                note_failure("event with nothing expected", '0, got);
            end else begin
                want = pending_events.pop_front();
                if (got.ev.kind !== want.ev.kind || got.ev.btn !== want.ev.btn ||
                    got.ev.ex !== want.ev.ex || got.ev.ey !== want.ev.ey ||
                    got.ev.sx !== want.ev.sx || got.ev.sy !== want.ev.sy ||
                    got.ev.dx !== want.ev.dx || got.ev.dy !== want.ev.dy ||
                    got.last !== want.last) begin
                    note_failure("event mismatch", want, got);
                end
            end
        end
    end

    // Ends the run when no transfer happens on any channel for too long.
    always @(posedge i_clk) begin : watchdog
        int quiet;
        if (!i_rst_n || (i_s_tvalid && o_s_tready === 1'b1) ||
            (o_m_tvalid === 1'b1 && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("mouse_button_gesture_detector_unit regression: fail");
            $finish;
        end
    end

endmodule
